[hw/rtl/ldsh_pkg.sv]
// Package for the Laplacian detail sharpener: shared types, constants and
// register codes. No dependencies.
package ldsh_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int COL_BITS      = 13;
    localparam int ROW_BITS      = 13;
    localparam int SAMP_BITS     = 8;
    localparam int GAIN_BITS     = 12;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int LAP_BITS      = 11;
    localparam int OUT_SHIFT     = 20;
    localparam logic [ROW_BITS-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd2048;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1080;
    localparam logic [11:0] RST_GAIN         = 12'd256;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_DETAIL_BOOST    = 2'd2,
        CFG_REFINE_STRENGTH = 2'd3
    } t_cfg_idx;

    // One classified item handed from front to back.
    typedef struct packed {
        logic [SAMP_BITS-1:0] sample;
        logic [COL_BITS-1:0]  col_t;     // column of the incoming sample
        logic [COL_BITS-1:0]  col_c;     // column of the Laplacian center
        logic                 c_int;     // Laplacian center is interior
        logic                 emit;      // item releases a result
        logic                 p_int;     // released pixel is interior
        logic                 fend;      // released pixel closes the plane
        logic [GAIN_BITS-1:0] boost;
        logic [GAIN_BITS-1:0] strength;
    } t_item;

endpackage

[hw/rtl/ldsh_front.sv]
// Front end: configuration registers, frame position tracking and item
// classification. Depends on ldsh_pkg.
module ldsh_front #(
    parameter int MAX_WIDTH = ldsh_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ldsh_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ldsh_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [ldsh_pkg::SAMP_BITS-1:0]        i_s_tdata,
    output logic                                  o_push,
    output ldsh_pkg::t_item                       o_item,
    input  logic                                  i_full
);

    logic [11:0] r_cfg_w;
    logic [12:0] r_cfg_h;
    logic [11:0] r_cfg_boost;
    logic [11:0] r_cfg_str;
    logic [11:0] r_w;
    logic [12:0] r_h;
    logic [11:0] r_boost;
    logic [11:0] r_str;
    logic [ldsh_pkg::COL_BITS-1:0] r_xt, n_xt, r_xp, n_xp;
    logic [ldsh_pkg::ROW_BITS-1:0] r_yt, n_yt, r_yp, n_yp;

    logic        pos0, accept;
    logic [11:0] clw, cur_w, cur_boost, cur_str;
    logic [12:0] clh, cur_h;
    logic [13:0] w14, h14, x14, y14, xp14, yp14, maxw14;
    logic        emit, fend, c_int, p_int;
    logic [ldsh_pkg::COL_BITS-1:0] col_c;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_full;
    assign accept      = i_s_tvalid && !i_full;
    assign pos0        = (r_xt == '0) && (r_yt == '0);

    always_comb begin
        maxw14 = 14'(MAX_WIDTH);
        if (r_cfg_w == 12'd0) begin
            clw = 12'd1;
        end else if ({2'b0, r_cfg_w} > maxw14) begin
            clw = maxw14[11:0];
        end else begin
            clw = r_cfg_w;
        end
        if (r_cfg_h == 13'd0) begin
            clh = 13'd1;
        end else if (r_cfg_h > ldsh_pkg::MAX_HEIGHT) begin
            clh = ldsh_pkg::MAX_HEIGHT;
        end else begin
            clh = r_cfg_h;
        end
        // a frame's first item already sees the freshly latched values
        cur_w     = pos0 ? clw : r_w;
        cur_h     = pos0 ? clh : r_h;
        cur_boost = pos0 ? r_cfg_boost : r_boost;
        cur_str   = pos0 ? r_cfg_str : r_str;

        w14  = {2'b0, cur_w};
        h14  = {1'b0, cur_h};
        x14  = {1'b0, r_xt};
        y14  = {1'b0, r_yt};
        xp14 = {1'b0, r_xp};
        yp14 = {1'b0, r_yp};

        if (w14 >= 14'd3) begin
            emit = (y14 > 14'd2) || ((y14 == 14'd2) && (x14 >= 14'd2));
        end else if (w14 == 14'd2) begin
            emit = (y14 >= 14'd3);
        end else begin
            emit = (y14 >= 14'd4);
        end
        if (w14 >= 14'd2) begin
            fend = (y14 == h14 + 14'd2) && (x14 == 14'd1);
        end else begin
            fend = (y14 == h14 + 14'd3);
        end
        c_int = (x14 >= 14'd2) && (y14 >= 14'd2) && (y14 + 14'd1 <= h14);
        p_int = (xp14 >= 14'd1) && (xp14 + 14'd2 <= w14)
             && (yp14 >= 14'd1) && (yp14 + 14'd2 <= h14);
        col_c = (r_xt == '0) ? (ldsh_pkg::COL_BITS'(cur_w) - 1'b1) : (r_xt - 1'b1);

        if (fend) begin
            n_xt = '0;
            n_yt = '0;
        end else if (x14 + 14'd1 >= w14) begin
            n_xt = '0;
            n_yt = r_yt + 1'b1;
        end else begin
            n_xt = r_xt + 1'b1;
            n_yt = r_yt;
        end
        if (fend) begin
            n_xp = '0;
            n_yp = '0;
        end else if (emit) begin
            if (xp14 + 14'd1 >= w14) begin
                n_xp = '0;
                n_yp = r_yp + 1'b1;
            end else begin
                n_xp = r_xp + 1'b1;
                n_yp = r_yp;
            end
        end else begin
            n_xp = r_xp;
            n_yp = r_yp;
        end

        o_item.sample   = i_s_tdata;
        o_item.col_t    = r_xt;
        o_item.col_c    = col_c;
        o_item.c_int    = c_int;
        o_item.emit     = emit;
        o_item.p_int    = p_int;
        o_item.fend     = fend;
        o_item.boost    = cur_boost;
        o_item.strength = cur_str;
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= ldsh_pkg::RST_FRAME_WIDTH;
            r_cfg_h     <= ldsh_pkg::RST_FRAME_HEIGHT;
            r_cfg_boost <= ldsh_pkg::RST_GAIN;
            r_cfg_str   <= ldsh_pkg::RST_GAIN;
            r_xt        <= '0;
            r_yt        <= '0;
            r_xp        <= '0;
            r_yp        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (ldsh_pkg::t_cfg_idx'(i_cfg_index))
                    ldsh_pkg::CFG_FRAME_WIDTH:     r_cfg_w     <= i_cfg_data[11:0];
                    ldsh_pkg::CFG_FRAME_HEIGHT:    r_cfg_h     <= i_cfg_data[12:0];
                    ldsh_pkg::CFG_DETAIL_BOOST:    r_cfg_boost <= i_cfg_data[11:0];
                    ldsh_pkg::CFG_REFINE_STRENGTH: r_cfg_str   <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_xt <= n_xt;
                r_yt <= n_yt;
                r_xp <= n_xp;
                r_yp <= n_yp;
            end
        end
    end

    // frame geometry and gains, held for the whole frame
    always_ff @(posedge i_clk) begin
        if (accept && pos0) begin
            r_w     <= clw;
            r_h     <= clh;
            r_boost <= r_cfg_boost;
            r_str   <= r_cfg_str;
        end
    end

endmodule

[hw/rtl/ldsh_fifo.sv]
// Two-entry queue between front and back end. Depends on ldsh_pkg.
module ldsh_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ldsh_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ldsh_pkg::t_item o_item
);

    ldsh_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[hw/rtl/ldsh_back.sv]
// Back end: line memories, Laplacian, smoothing, gain and saturation.
// Depends on ldsh_pkg.
module ldsh_back #(
    parameter int MAX_WIDTH = ldsh_pkg::MAX_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ldsh_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LB = ldsh_pkg::LAP_BITS;

    // line memories, indexed by column
    logic [15:0]     r_smem [MAX_WIDTH];   // {row-1 sample, row-2 sample}
    logic [2*LB-1:0] r_dmem [MAX_WIDTH];   // {row-1 Laplacian, row-2 Laplacian}
    logic [15:0]     r_srd;
    logic [2*LB-1:0] r_drd;

    ldsh_pkg::t_item r_ex;
    logic            r_ex_vld;
    logic            en, ex_fire;

    // sample and Laplacian taps
    logic [7:0] r_r1d1, r_r1d2, r_r2d1, r_r2d2, r_sd1;
    logic signed [12:0] r_v0, r_v1, r_v2;

    logic signed [12:0] lap13;
    logic signed [LB-1:0] lap, lup1, lup2;
    logic signed [12:0] vnew;

    logic        r_a_vld, r_a_pint, r_a_fend;
    logic [7:0]  r_a_samp;
    logic [11:0] r_a_boost, r_a_str;

    logic        r_b_vld, r_b_pint, r_b_fend;
    logic [7:0]  r_b_samp;
    logic signed [14:0] r_b_k;
    logic [23:0] r_b_gain;

    logic        r_c_vld, r_c_pint, r_c_fend;
    logic [7:0]  r_c_samp;
    logic signed [39:0] r_c_prod;

    logic signed [40:0] total;
    logic [7:0]  sat;

    logic        r_out_vld, r_out_last;
    logic [7:0]  r_out_pix;

    assign en      = !r_out_vld || i_m_tready;
    assign o_pop   = en && !r_ex_vld && !i_empty;
    assign ex_fire = en && r_ex_vld;

    always_comb begin
        lup1  = r_drd[2*LB-1:LB];
        lup2  = r_drd[LB-1:0];
        // center s(t-W-1), left s(t-W-2), right s(t-W), up s(t-2W-1), down s(t-1)
        lap13 = $signed({3'b0, r_r1d1, 2'b0}) - $signed({5'b0, r_r1d2})
              - $signed({5'b0, r_srd[15:8]}) - $signed({5'b0, r_r2d1})
              - $signed({5'b0, r_sd1});
        lap   = r_ex.c_int ? lap13[LB-1:0] : '0;
        vnew  = 13'(lup2) + 13'(lup1) + 13'(lup1) + 13'(lap);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ex  <= i_item;
            r_srd <= r_smem[i_item.col_t[AW-1:0]];
            r_drd <= r_dmem[i_item.col_c[AW-1:0]];
        end
        if (ex_fire) begin
            r_smem[r_ex.col_t[AW-1:0]] <= {r_ex.sample, r_srd[15:8]};
            r_dmem[r_ex.col_c[AW-1:0]] <= {lap, lup1};
            r_sd1  <= r_ex.sample;
            r_r1d1 <= r_srd[15:8];
            r_r1d2 <= r_r1d1;
            r_r2d1 <= r_srd[7:0];
            r_r2d2 <= r_r2d1;
            r_v0   <= vnew;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_a_samp  <= r_r2d2;          // s(t-2W-2), the released pixel
            r_a_pint  <= r_ex.p_int;
            r_a_fend  <= r_ex.fend;
            r_a_boost <= r_ex.boost;
            r_a_str   <= r_ex.strength;
        end
        if (en) begin
            r_b_samp <= r_a_samp;
            r_b_pint <= r_a_pint;
            r_b_fend <= r_a_fend;
            r_b_k    <= 15'(r_v2) + 15'(r_v1) + 15'(r_v1) + 15'(r_v0);
            r_b_gain <= r_a_boost * r_a_str;
            r_c_samp <= r_b_samp;
            r_c_pint <= r_b_pint;
            r_c_fend <= r_b_fend;
            r_c_prod <= r_b_k * $signed({1'b0, r_b_gain});
        end
    end

    always_comb begin
        total = $signed({13'b0, r_c_samp, 20'b0}) + 41'(r_c_prod)
              + $signed(41'(1) <<< (ldsh_pkg::OUT_SHIFT - 1));
        if (total[40]) begin
            sat = 8'd0;
        end else if (total[39:ldsh_pkg::OUT_SHIFT] > 20'd255) begin
            sat = 8'd255;
        end else begin
            sat = total[ldsh_pkg::OUT_SHIFT+7:ldsh_pkg::OUT_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ex_vld <= 1'b1;
            end else if (ex_fire) begin
                r_ex_vld <= 1'b0;
            end
            if (en) begin
                r_a_vld   <= ex_fire && r_ex.emit;
                r_b_vld   <= r_a_vld;
                r_c_vld   <= r_b_vld;
                r_out_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pix  <= r_c_pint ? sat : r_c_samp;
            r_out_last <= r_c_fend;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tlast  = r_out_last;

    // memory read and write of one item never share a cycle
    a_pop_not_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !ex_fire)
        else $error("pop and execute in the same cycle");

    a_ex_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_fire |=> !ex_fire)
        else $error("back-to-back execute without a read cycle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> ($stable(r_c_vld) && $stable(r_v0)))
        else $error("pipeline moved during an output stall");

endmodule

[hw/rtl/laplacian_detail_sharpen_top.sv]
// A result reaches the output after the item that releases it is transferred in,
// passing the queue, line-memory read, execute, two math stages and output.
// The back end reads and then writes its line memories for each item, so it takes
// a new item only after the last has executed; output stalls also hold the flow.
// Reset: synchronous, active low; clears counters, queue and valid flags and
// loads register defaults. Line memories are not cleared.
module laplacian_detail_sharpen_top #(
    parameter int MAX_WIDTH = ldsh_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ldsh_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [ldsh_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] sample
    input  logic                               i_s_tuser,   // [0] drain
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // [7:0] pixel_out
    output logic                               o_m_tlast    // frame_end
);

    ldsh_pkg::t_item push_item, pop_item;
    logic            push, pop, full, empty;
    logic            drain_seen;

    // frame position alone tells pixels from drain items
    assign drain_seen = i_s_tuser;

    ldsh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid || (drain_seen && 1'b0)),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_push      (push),
        .o_item      (push_item),
        .i_full      (full)
    );

    ldsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (pop_item)
    );

    ldsh_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
